// ===== hw/rtl/lwws_pkg.sv =====
// ----------------------------------------------------------------------------
// lwws_pkg
// Shared types and constants for the lcd window write sequencer.
// ----------------------------------------------------------------------------
package lwws_pkg;

    // controller opcode bases
    localparam logic [7:0] CMD_COL_HI = 8'h10;
    localparam logic [7:0] CMD_COL_LO = 8'h00;
    localparam logic [7:0] CMD_PAGE   = 8'hB0;

    localparam int JOB_DEPTH_DEF = 2;

    // reset values of the window registers
    localparam logic [3:0] LAST_PAGE_RST = 4'h7;

    typedef enum logic {
        OP_SET_POS    = 1'b0,
        OP_WRITE_DATA = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        REG_VERTICAL_MODE = 3'd0,
        REG_FIRST_COLUMN  = 3'd1,
        REG_LAST_COLUMN   = 3'd2,
        REG_FIRST_PAGE    = 3'd3,
        REG_LAST_PAGE     = 3'd4,
        REG_COLUMN_OFFSET = 3'd5
    } t_reg_idx;

    // one classified request, waiting to be serialized
    typedef struct packed {
        logic       has_data;
        logic       has_addr;
        logic [7:0] data;
        logic [7:0] col_addr;   // column with offset applied
        logic [3:0] page;
        logic       last;
    } t_job;

endpackage

// ===== hw/rtl/lwws_front.sv =====
// ----------------------------------------------------------------------------
// lwws_front
// Holds the window registers and the write position, and turns each request
// into a job: an optional data byte and an optional address reload.
// ----------------------------------------------------------------------------
module lwws_front
    import lwws_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_take,
    input  logic       i_op,
    input  logic [3:0] i_row,
    input  logic [7:0] i_column,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_in_burst,
    output t_job       o_job
);

    logic       r_vertical;
    logic [7:0] r_first_col;
    logic [7:0] r_last_col;
    logic [3:0] r_first_page;
    logic [3:0] r_last_page;
    logic [7:0] r_col_offset;
    logic [7:0] r_col;
    logic [3:0] r_page;

    logic [7:0] n_col;
    logic [3:0] n_page;
    logic       col_wrap;
    logic       page_wrap;
    logic [7:0] col_step;
    logic [3:0] page_step;
    logic       has_addr;

    always_comb begin
        col_wrap  = (r_col >= r_last_col);
        col_step  = col_wrap ? r_first_col : r_col + 8'd1;
        page_wrap = (r_page >= r_last_page);
        page_step = page_wrap ? r_first_page : r_page + 4'd1;

        if (t_op'(i_op) == OP_SET_POS) begin
            n_col    = i_column;
            n_page   = i_row;
            has_addr = 1'b1;
        end else if (r_vertical) begin
            n_page   = page_step;
            n_col    = page_wrap ? col_step : r_col;
            has_addr = 1'b1;
        end else begin
            n_col    = col_step;
            n_page   = col_wrap ? page_step : r_page;
            // address reload only on a row wrap
            has_addr = col_wrap;
        end

        o_job.has_data = (t_op'(i_op) == OP_WRITE_DATA);
        o_job.has_addr = has_addr;
        o_job.data     = i_data_byte;
        o_job.col_addr = n_col + r_col_offset;
        o_job.page     = n_page;
        o_job.last     = i_last_in_burst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertical   <= 1'b0;
            r_first_col  <= 8'd0;
            r_last_col   <= 8'd0;
            r_first_page <= 4'd0;
            r_last_page  <= LAST_PAGE_RST;
            r_col_offset <= 8'd0;
            r_col        <= 8'd0;
            r_page       <= 4'd0;
        end else begin
            if (i_cfg_valid) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_VERTICAL_MODE: r_vertical   <= i_cfg_data[0];
                    REG_FIRST_COLUMN:  r_first_col  <= i_cfg_data;
                    REG_LAST_COLUMN:   r_last_col   <= i_cfg_data;
                    REG_FIRST_PAGE:    r_first_page <= i_cfg_data[3:0];
                    REG_LAST_PAGE:     r_last_page  <= i_cfg_data[3:0];
                    REG_COLUMN_OFFSET: r_col_offset <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_take) begin
                r_col  <= n_col;
                r_page <= n_page;
            end
        end
    end

endmodule

// ===== hw/rtl/lwws_fifo.sv =====
// ----------------------------------------------------------------------------
// lwws_fifo
// Short job queue between the front and the serializer.
// ----------------------------------------------------------------------------
module lwws_fifo
    import lwws_pkg::*;
#(
    parameter int DEPTH = JOB_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== hw/rtl/lwws_back.sv =====
// ----------------------------------------------------------------------------
// lwws_back
// Serializes the queued job into controller bytes, one per cycle while the
// output register, read like a queue head, is empty or popped.
// ----------------------------------------------------------------------------
module lwws_back
    import lwws_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  logic       i_job_empty,
    output logic       o_job_pop,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_out_byte,
    output logic       o_is_command,
    output logic       o_last_of_item,
    output logic       o_burst_end
);

    typedef enum logic [1:0] {
        S_DATA   = 2'd0,
        S_COL_HI = 2'd1,
        S_COL_LO = 2'd2,
        S_PAGE   = 2'd3
    } t_step;

    t_step      r_step;
    logic       r_first;      // next byte is the first of the head job
    logic       r_out_valid;
    logic [7:0] r_byte;
    logic       r_cmd;
    logic       r_last;
    logic       r_burst;

    t_step      cur;
    t_step      nxt;
    logic       adv;
    logic       fire;
    logic       final_step;
    logic [7:0] byte_val;
    logic       cmd_val;

    always_comb begin
        if (r_first) begin
            cur = i_job.has_data ? S_DATA : S_COL_HI;
        end else begin
            cur = r_step;
        end

        final_step = (cur == S_PAGE) || ((cur == S_DATA) && !i_job.has_addr);

        case (cur)
            S_DATA: begin
                byte_val = i_job.data;
                cmd_val  = 1'b0;
                nxt      = S_COL_HI;
            end
            S_COL_HI: begin
                byte_val = CMD_COL_HI | {4'h0, i_job.col_addr[7:4]};
                cmd_val  = 1'b1;
                nxt      = S_COL_LO;
            end
            S_COL_LO: begin
                byte_val = CMD_COL_LO | {4'h0, i_job.col_addr[3:0]};
                cmd_val  = 1'b1;
                nxt      = S_PAGE;
            end
            S_PAGE: begin
                byte_val = CMD_PAGE | {4'h0, i_job.page};
                cmd_val  = 1'b1;
                nxt      = S_DATA;
            end
            default: begin
                byte_val = i_job.data;
                cmd_val  = 1'b0;
                nxt      = S_DATA;
            end
        endcase
    end

    assign adv       = !r_out_valid || i_pop;
    assign fire      = adv && !i_job_empty;
    assign o_job_pop = fire && final_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_DATA;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= !i_job_empty;
            end
            if (fire) begin
                r_first <= final_step;
                r_step  <= nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_byte  <= byte_val;
            r_cmd   <= cmd_val;
            r_last  <= final_step;
            r_burst <= final_step && i_job.last;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_out_byte     = r_byte;
    assign o_is_command   = r_cmd;
    assign o_last_of_item = r_last;
    assign o_burst_end    = r_burst;

endmodule

// ===== hw/rtl/lcd_window_write_sequencer.sv =====
// ----------------------------------------------------------------------------
// lcd_window_write_sequencer
// Window write sequencer for a page-organized lcd controller.
// ----------------------------------------------------------------------------
// A request either sets the write position or carries one display byte. The
// front classifies each request in the cycle it is taken, updates the
// position and queues a job; the serializer then emits one controller byte
// per cycle from the queue head while the output is empty or popped. A
// set-position request yields three command bytes, a data request one byte
// plus three address commands in vertical mode or on a row wrap, so a request
// yields one, three or four output bytes; sustained intake is bounded by the
// single-byte-per-cycle serializer. Requests are taken back to back until the
// job queue (JOB_DEPTH entries) fills. Config writes are always ready and
// should be made while the block is idle.
module lcd_window_write_sequencer
    import lwws_pkg::*;
#(
    parameter int JOB_DEPTH = JOB_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       push,
    output logic       full,
    input  logic       i_op,
    input  logic [3:0] i_row,
    input  logic [7:0] i_column,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_in_burst,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_is_command,
    output logic       o_last_of_item,
    output logic       o_burst_end
);

    t_job front_job;
    t_job head_job;
    logic take;
    logic job_empty;
    logic job_pop;

    assign o_cfg_ready = 1'b1;
    assign take        = push && !full;

    lwws_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_take         (take),
        .i_op           (i_op),
        .i_row          (i_row),
        .i_column       (i_column),
        .i_data_byte    (i_data_byte),
        .i_last_in_burst(i_last_in_burst),
        .o_job          (front_job)
    );

    lwws_fifo #(
        .DEPTH(JOB_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (take),
        .i_job  (front_job),
        .o_full (full),
        .i_pop  (job_pop),
        .o_job  (head_job),
        .o_empty(job_empty)
    );

    lwws_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (head_job),
        .i_job_empty   (job_empty),
        .o_job_pop     (job_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_out_byte    (o_out_byte),
        .o_is_command  (o_is_command),
        .o_last_of_item(o_last_of_item),
        .o_burst_end   (o_burst_end)
    );

endmodule

// ===== hw/rtl/lwws_checker.sv =====
// ----------------------------------------------------------------------------
// lwws_checker
// Port-level checks on the output stream of the window write sequencer.
// ----------------------------------------------------------------------------
module lwws_checker
    import lwws_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_is_command,
    input logic       o_last_of_item,
    input logic       o_burst_end
);

    // waiting result stays put until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte)))
        else $error("result changed or vanished while stalled");

    a_burst_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_burst_end) |-> o_last_of_item)
        else $error("burst end on a result that does not close its request");

    // an address sequence always closes with the page command
    a_cmd_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_is_command && o_last_of_item) |->
        (o_out_byte[7:4] == CMD_PAGE[7:4]))
        else $error("closing command is not a page command");

    // data byte with reload is followed at once by column high
    a_data_then_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_is_command && !o_last_of_item) |=>
        (!empty && o_is_command && (o_out_byte[7:4] == CMD_COL_HI[7:4])))
        else $error("address reload does not follow data byte");

endmodule

bind lcd_window_write_sequencer lwws_checker u_lwws_checker (.*);
